// ===== hw/rtl/sed_pkg.sv =====
// Shared types, command codes and helpers of the SPI EEPROM device.
`default_nettype none

package sed_pkg;

  // Request kinds carried on req_type.
  typedef enum logic [1:0] {
    OP_SEL   = 2'd0,
    OP_XCHG  = 2'd1,
    OP_DESEL = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Command class of the byte in an exchange, resolved at the front.
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_READ  = 3'd1,
    CLS_WRITE = 3'd2,
    CLS_RDSR  = 3'd3,
    CLS_WREN  = 3'd4
  } cls_t;

  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] UID_FIRST = 8'hFA;
  localparam logic [7:0] UID_LAST  = 8'hFF;
  localparam logic [7:0] NO_DRIVE  = 8'hFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CYCLE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_ID         = 1'd1;

  localparam logic [15:0] TICKS_RESET = 16'd500;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic [7:0] miso;
    logic       busy;
  } res_t;

  // Byte of the unique ID at offset ofs from the first ID address, MSB first.
  function automatic logic [7:0] uid_byte(input logic [47:0] uid, input logic [2:0] ofs);
    logic [7:0] b;
    case (ofs)
      3'd0:    b = uid[47:40];
      3'd1:    b = uid[39:32];
      3'd2:    b = uid[31:24];
      3'd3:    b = uid[23:16];
      3'd4:    b = uid[15:8];
      3'd5:    b = uid[7:0];
      default: b = NO_DRIVE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sed_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sed_fifo.sv =====
// Two-entry queue used between the front, the back and the result port.
`default_nettype none

module sed_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entry[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sed_front.sv =====
// Front end: takes bus requests, decodes the command class and queues them.
`default_nettype none

module sed_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [1:0]      req_type,
  input  wire logic [7:0]      mosi_byte,
  input  wire logic            clearing,
  input  wire logic            item_pop,
  output logic                 item_valid,
  output sed_pkg::item_t       item
);

  import sed_pkg::*;

  item_t item_in;
  logic  q_full;
  logic  q_empty;
  logic [$bits(item_t)-1:0] q_rdata;

  always_comb begin
    item_in.op   = op_t'(req_type);
    item_in.data = mosi_byte;
    case (mosi_byte)
      CMD_READ:  item_in.cls = CLS_READ;
      CMD_WRITE: item_in.cls = CLS_WRITE;
      CMD_RDSR:  item_in.cls = CLS_RDSR;
      CMD_WREN:  item_in.cls = CLS_WREN;
      default:   item_in.cls = CLS_OTHER;
    endcase
  end

  // No beat is taken while the cell array is being erased after reset.
  assign full       = q_full || clearing;
  assign item_valid = !q_empty;
  assign item       = item_t'(q_rdata);

  sed_fifo #(
    .WIDTH($bits(item_t))
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && !full),
    .wr_data(item_in),
    .full   (q_full),
    .rd_en  (item_pop),
    .rd_data(q_rdata),
    .empty  (q_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sed_back.sv =====
// Back end: SPI transaction state, cell array, page buffer and page commit.
`default_nettype none

module sed_back #(
  parameter int MEM_BYTES  = 256,
  parameter int PAGE_BYTES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [15:0]     write_cycle_ticks,
  input  wire logic [47:0]     unique_id,
  input  wire logic            item_valid,
  input  wire sed_pkg::item_t  item,
  output logic                 item_pop,
  output logic                 clearing,
  input  wire logic            res_full,
  output logic                 res_push,
  output sed_pkg::res_t        res
);

  import sed_pkg::*;

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int PW  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int NW  = $clog2(PAGE_BYTES + 1);
  localparam int CW  = (AW > 8) ? AW : 8;
  localparam int TW0 = (AW > PW) ? AW : PW;
  localparam int TW  = ((TW0 > 8) ? TW0 : 8) + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_ADDR,
    PH_DATA,
    PH_IGNORE
  } phase_t;

  state_t          state, state_next;
  phase_t          phase, phase_next;
  cls_t            cmd, cmd_next;
  logic            selected, selected_next;
  logic            wel, wel_next;
  logic [15:0]     busy_cnt, busy_cnt_next;
  logic [AW-1:0]   addr, addr_next;
  logic [AW-1:0]   page_base, page_base_next;
  logic [PW-1:0]   page_off, page_off_next;
  logic            page_any, page_any_next;
  logic [PAGE_BYTES-1:0] page_valid, page_valid_next;
  logic [AW-1:0]   clr_idx, clr_idx_next;
  logic [NW-1:0]   cmt_idx, cmt_idx_next;

  logic [CW-1:0]   byte_w;
  logic [AW-1:0]   new_addr;
  logic [TW-1:0]   new_addr_p;
  logic [TW-1:0]   new_off_p;
  logic [CW-1:0]   addr_w;
  logic            uid_hit;
  logic [2:0]      uid_ofs;
  logic            busy;
  logic [NW-1:0]   cmt_prev;
  logic [PW-1:0]   cmt_slot;
  logic [TW-1:0]   cmt_target;
  logic            cmt_keep;

  logic            cell_we;
  logic [AW-1:0]   cell_waddr;
  logic [7:0]      cell_wdata;
  logic [7:0]      cell_rdata;
  logic            page_we;
  logic [7:0]      page_rdata;

  assign busy       = (busy_cnt != 16'd0);
  assign clearing   = (state == ST_CLEAR);

  assign byte_w     = CW'(item.data);
  assign new_addr   = byte_w[AW-1:0];
  assign new_addr_p = TW'(new_addr);
  assign new_off_p  = TW'(new_addr_p % PAGE_BYTES);

  assign addr_w     = CW'(addr);
  assign uid_hit    = (addr_w >= CW'(UID_FIRST)) && (addr_w <= CW'(UID_LAST));
  assign uid_ofs    = addr_w[2:0] - UID_FIRST[2:0];

  // The page buffer read is registered, so the write of slot k lands in the
  // cycle after its read was issued.
  assign cmt_prev   = cmt_idx - NW'(1);
  assign cmt_slot   = PW'(cmt_prev);
  assign cmt_target = TW'(page_base) + TW'(cmt_slot);
  assign cmt_keep   = (cmt_target >= TW'(UID_FIRST)) && (cmt_target <= TW'(UID_LAST));

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    cmd_next        = cmd;
    selected_next   = selected;
    wel_next        = wel;
    busy_cnt_next   = busy_cnt;
    addr_next       = addr;
    page_base_next  = page_base;
    page_off_next   = page_off;
    page_any_next   = page_any;
    page_valid_next = page_valid;
    clr_idx_next    = clr_idx;
    cmt_idx_next    = cmt_idx;
    item_pop        = 1'b0;
    res_push        = 1'b0;
    res.miso        = NO_DRIVE;
    cell_we         = 1'b0;
    cell_waddr      = clr_idx;
    cell_wdata      = NO_DRIVE;
    page_we         = 1'b0;

    case (state)
      ST_CLEAR: begin
        cell_we      = 1'b1;
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == AW'(MEM_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (item_valid && !res_full) begin
          item_pop = 1'b1;
          res_push = 1'b1;
          case (item.op)
            OP_SEL: begin
              selected_next   = 1'b1;
              phase_next      = PH_CMD;
              cmd_next        = CLS_OTHER;
              page_valid_next = '0;
              page_any_next   = 1'b0;
              page_base_next  = '0;
              page_off_next   = '0;
            end

            OP_XCHG: begin
              if (selected) begin
                case (phase)
                  PH_CMD: begin
                    cmd_next = item.cls;
                    if (busy && item.cls != CLS_RDSR) begin
                      phase_next = PH_IGNORE;
                    end else begin
                      case (item.cls)
                        CLS_READ:  phase_next = PH_ADDR;
                        CLS_WRITE: phase_next = wel ? PH_ADDR : PH_IGNORE;
                        CLS_RDSR:  phase_next = PH_DATA;
                        default:   phase_next = PH_IGNORE;
                      endcase
                    end
                  end

                  PH_ADDR: begin
                    addr_next = new_addr;
                    if (cmd == CLS_WRITE) begin
                      page_off_next  = PW'(new_off_p);
                      page_base_next = AW'(new_addr_p - new_off_p);
                    end
                    phase_next = PH_DATA;
                  end

                  PH_DATA: begin
                    case (cmd)
                      CLS_READ: begin
                        addr_next = addr + AW'(1);
                        if (uid_hit) begin
                          res.miso = uid_byte(unique_id, uid_ofs);
                        end else begin
                          // Cell data come back from the array next cycle.
                          res_push   = 1'b0;
                          state_next = ST_READ;
                        end
                      end
                      CLS_WRITE: begin
                        page_we                   = 1'b1;
                        page_valid_next[page_off] = 1'b1;
                        page_any_next             = 1'b1;
                        page_off_next = PW'((TW'(page_off) + TW'(1)) % PAGE_BYTES);
                      end
                      CLS_RDSR: begin
                        res.miso = {6'd0, wel, busy};
                      end
                      default: begin
                      end
                    endcase
                  end

                  default: begin
                  end
                endcase
              end
            end

            OP_DESEL: begin
              if (selected) begin
                if (phase == PH_DATA && cmd == CLS_WRITE && page_any) begin
                  res_push     = 1'b0;
                  cmt_idx_next = '0;
                  state_next   = ST_COMMIT;
                end else begin
                  if (phase == PH_IGNORE && cmd == CLS_WREN && !busy) begin
                    wel_next = 1'b1;
                  end
                  selected_next   = 1'b0;
                  phase_next      = PH_CMD;
                  page_valid_next = '0;
                  page_any_next   = 1'b0;
                  page_base_next  = '0;
                  page_off_next   = '0;
                end
              end
            end

            default: begin
              if (busy) begin
                busy_cnt_next = busy_cnt - 16'd1;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        res_push   = 1'b1;
        res.miso   = cell_rdata;
        state_next = ST_IDLE;
      end

      default: begin
        cmt_idx_next = cmt_idx + NW'(1);
        if (cmt_idx != '0) begin
          cell_waddr = AW'(cmt_target);
          cell_wdata = page_rdata;
          cell_we    = page_valid[cmt_slot] && (cmt_target < TW'(MEM_BYTES)) && !cmt_keep;
        end
        if (cmt_idx == NW'(PAGE_BYTES)) begin
          wel_next        = 1'b0;
          busy_cnt_next   = write_cycle_ticks;
          selected_next   = 1'b0;
          phase_next      = PH_CMD;
          page_valid_next = '0;
          page_any_next   = 1'b0;
          page_base_next  = '0;
          page_off_next   = '0;
          res_push        = 1'b1;
          state_next      = ST_IDLE;
        end
      end
    endcase

    res.busy = (busy_cnt_next != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      phase      <= PH_CMD;
      cmd        <= CLS_OTHER;
      selected   <= 1'b0;
      wel        <= 1'b0;
      busy_cnt   <= 16'd0;
      addr       <= '0;
      page_base  <= '0;
      page_off   <= '0;
      page_any   <= 1'b0;
      page_valid <= '0;
      clr_idx    <= '0;
      cmt_idx    <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      cmd        <= cmd_next;
      selected   <= selected_next;
      wel        <= wel_next;
      busy_cnt   <= busy_cnt_next;
      addr       <= addr_next;
      page_base  <= page_base_next;
      page_off   <= page_off_next;
      page_any   <= page_any_next;
      page_valid <= page_valid_next;
      clr_idx    <= clr_idx_next;
      cmt_idx    <= cmt_idx_next;
    end
  end

  sed_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_cells (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .raddr(addr),
    .rdata(cell_rdata)
  );

  sed_ram #(
    .WIDTH(8),
    .DEPTH(PAGE_BYTES)
  ) u_page (
    .clk  (clk),
    .we   (page_we),
    .waddr(page_off),
    .wdata(item.data),
    .raddr(PW'(cmt_idx)),
    .rdata(page_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/spi_eeprom_device_unit.sv =====
// Top level of the SPI EEPROM device: config registers, front, back, result queue.
//
// Channel   Direction  Handshake        Payload
// request   in         push / full      req_type, mosi_byte
// result    out        empty / pop      miso_byte, busy_res
// config    in         cfg_valid/ready  cfg_index, cfg_data
//
// A request beat passes the request queue, the back end and the result queue; a
// read data byte also waits for the registered cell array read. A deassert that
// commits a page walks the page buffer one slot per cycle before its result.
// While the cell array is erased to 0xFF after reset, full stays high.
// MEM_BYTES and PAGE_BYTES must be powers of two; the block does not check this.
// Up to two requests and two results are buffered, so each side stalls alone.
`default_nettype none

module spi_eeprom_device_unit #(
  parameter int MEM_BYTES  = 256,
  parameter int PAGE_BYTES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [1:0]                       req_type,
  input  wire logic [7:0]                       mosi_byte,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic      [7:0]                       miso_byte,
  output logic                                  busy_res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [47:0]                      cfg_data
);

  import sed_pkg::*;

  logic [15:0] write_cycle_ticks;
  logic [47:0] unique_id;
  logic        item_valid;
  item_t       item;
  logic        item_pop;
  logic        clearing;
  logic        res_full;
  logic        res_push;
  res_t        res;
  res_t        res_out;
  logic [$bits(res_t)-1:0] res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_cycle_ticks <= TICKS_RESET;
      unique_id         <= 48'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WRITE_CYCLE_TICKS: write_cycle_ticks <= cfg_data[15:0];
        CFG_UNIQUE_ID:         unique_id         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .mosi_byte (mosi_byte),
    .clearing  (clearing),
    .item_pop  (item_pop),
    .item_valid(item_valid),
    .item      (item)
  );

  sed_back #(
    .MEM_BYTES (MEM_BYTES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .write_cycle_ticks(write_cycle_ticks),
    .unique_id        (unique_id),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop),
    .clearing         (clearing),
    .res_full         (res_full),
    .res_push         (res_push),
    .res              (res)
  );

  sed_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_rdata),
    .empty  (empty)
  );

  assign res_out   = res_t'(res_rdata);
  assign miso_byte = res_out.miso;
  assign busy_res  = res_out.busy;

  // Every result the back end produces must find room in the result queue.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // The back end only takes a request that the front end holds.
  a_pop_with_item: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("request popped from an empty queue");

  // While the erase pass runs, no request beat may be taken.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> full)
    else $error("request port open during erase pass");

  // A tick taken from the request queue yields its result in the same cycle.
  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    (item_pop && item.op == OP_TICK) |-> res_push)
    else $error("tick request produced no result");

endmodule

`default_nettype wire

// ===== dv/spi_eeprom_device_unit_tb.sv =====
// Self-checking testbench for the SPI EEPROM device: predictor, scoreboard, traffic.
`timescale 1ns / 1ps

module spi_eeprom_device_unit_tb;
  import sed_pkg::*;

  localparam int          CELL_COUNT  = 256;
  localparam int          PAGE_SIZE   = 16;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [7:0]  BOGUS_CMD   = 8'h9C;
  localparam logic [47:0] UID_ALL_ONE = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_ADDR,
    PH_DATA,
    PH_SKIP
  } bus_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           req_type = 2'd0;
  logic [7:0]           mosi_byte = 8'd0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           miso_byte;
  logic                 busy_res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [47:0]          cfg_data = '0;

  spi_eeprom_device_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .mosi_byte (mosi_byte),
    .empty     (empty),
    .pop       (pop),
    .miso_byte (miso_byte),
    .busy_res  (busy_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted device state.
  logic [7:0]  m_cells [CELL_COUNT];
  logic [15:0] m_ticks;
  logic [47:0] m_uid;
  logic        m_sel;
  bus_phase_t  m_phase;
  logic [7:0]  m_cmd;
  logic [7:0]  m_addr;
  logic        m_wel;
  logic [15:0] m_busy;
  logic [7:0]  pg_buf [PAGE_SIZE];
  logic        pg_vld [PAGE_SIZE];
  logic [7:0]  pg_base;
  logic [3:0]  pg_off;
  logic        pg_any;

  res_t due_res_q[$];
  res_t head_res;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic page_clear();
    for (int i = 0; i < PAGE_SIZE; i++) begin
      pg_buf[i] = 8'hFF;
      pg_vld[i] = 1'b0;
    end
    pg_any = 1'b0;
    pg_base = '0;
    pg_off = '0;
  endtask

  // Advances the predicted device by one accepted request beat.
  task automatic eeprom_predict(input op_t op, input logic [7:0] b);
    res_t r;
    logic [7:0] t;
    r.miso = NO_DRIVE;
    case (op)
      OP_SEL: begin
        m_sel = 1'b1;
        m_phase = PH_CMD;
        m_cmd = '0;
        page_clear();
      end
      OP_XCHG: begin
        if (m_sel) begin
          case (m_phase)
            PH_CMD: begin
              m_cmd = b;
              if (m_busy != 0 && b != CMD_RDSR) m_phase = PH_SKIP;
              else if (b == CMD_READ) m_phase = PH_ADDR;
              else if (b == CMD_WRITE) m_phase = m_wel ? PH_ADDR : PH_SKIP;
              else if (b == CMD_RDSR) m_phase = PH_DATA;
              else m_phase = PH_SKIP;
            end
            PH_ADDR: begin
              m_addr = b;
              if (m_cmd == CMD_WRITE) begin
                pg_off = b[3:0];
                pg_base = {b[7:4], 4'h0};
              end
              m_phase = PH_DATA;
            end
            PH_DATA: begin
              if (m_cmd == CMD_READ) begin
                if (m_addr >= UID_FIRST) r.miso = 8'(m_uid >> (8 * (5 - (m_addr - UID_FIRST))));
                else r.miso = m_cells[m_addr];
                m_addr = m_addr + 8'd1;
              end else if (m_cmd == CMD_WRITE) begin
                pg_buf[pg_off] = b;
                pg_vld[pg_off] = 1'b1;
                pg_any = 1'b1;
                pg_off = pg_off + 4'd1;
              end else if (m_cmd == CMD_RDSR) begin
                r.miso = {6'd0, m_wel, m_busy != 0};
              end
            end
            default: ;
          endcase
        end
      end
      OP_DESEL: begin
        if (m_sel) begin
          if (m_phase == PH_DATA && m_cmd == CMD_WRITE && pg_any) begin
            // The ID bytes at the top of memory are read-only.
            for (int i = 0; i < PAGE_SIZE; i++) begin
              t = pg_base + 8'(i);
              if (pg_vld[i] && t < UID_FIRST) m_cells[t] = pg_buf[i];
            end
            m_wel = 1'b0;
            m_busy = m_ticks;
          end else if (m_phase == PH_SKIP && m_cmd == CMD_WREN && m_busy == 0) begin
            m_wel = 1'b1;
          end
          m_sel = 1'b0;
          m_phase = PH_CMD;
          page_clear();
        end
      end
      default: begin
        if (m_busy != 0) m_busy = m_busy - 16'd1;
      end
    endcase
    r.busy = (m_busy != 0);
    due_res_q.push_back(r);
  endtask

  // Presents one request beat and holds it until the device takes it.
  task automatic send_req(input op_t op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= op;
    mosi_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    eeprom_predict(op, b);
    beats_sent++;
  endtask

  task automatic xchg(input logic [7:0] b);
    send_req(OP_XCHG, b);
  endtask

  task automatic tick();
    send_req(OP_TICK, 8'($urandom_range(255)));
  endtask

  task automatic begin_txn(input logic [7:0] cmd);
    send_req(OP_SEL, 8'($urandom_range(255)));
    xchg(cmd);
  endtask

  task automatic end_txn();
    send_req(OP_DESEL, 8'($urandom_range(255)));
  endtask

  // Writes one register once every expected result is in and the commit engine is quiet.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
    push <= 1'b0;
    while (due_res_q.size() != 0) @(posedge clk);
    repeat (PAGE_SIZE + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WRITE_CYCLE_TICKS) m_ticks = value[15:0];
    else m_uid = value;
    cfg_writes++;
  endtask

  task automatic random_transaction();
    int kind;
    int n;
    logic [7:0] a;
    kind = $urandom_range(99);
    // Lean on the top page, where the ID bytes live.
    a = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 240)) : 8'($urandom_range(255));
    n = ($urandom_range(7) == 0) ? $urandom_range(20, 17) : $urandom_range(6);
    if (kind < 40) begin
      if ($urandom_range(9) != 0) begin
        while (m_busy != 0) tick();
      end
      if ($urandom_range(9) != 0) begin
        begin_txn(CMD_WREN);
        end_txn();
      end
      begin_txn(CMD_WRITE);
      xchg(a);
      repeat (n) xchg(8'($urandom_range(255)));
      if ($urandom_range(9) != 0) end_txn();
    end else if (kind < 70) begin
      begin_txn(CMD_READ);
      xchg(a);
      repeat (n) xchg(8'($urandom_range(255)));
      if ($urandom_range(9) != 0) end_txn();
    end else if (kind < 80) begin
      begin_txn(CMD_RDSR);
      repeat ($urandom_range(3, 1)) xchg(8'($urandom_range(255)));
      end_txn();
    end else if (kind < 88) begin
      repeat ($urandom_range(8, 1)) tick();
    end else begin
      repeat ($urandom_range(4, 1)) send_req(op_t'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  // Erased array, zero ID, idle status, and beats that arrive while not selected.
  task automatic test_reset_state();
    xchg(8'h55);
    end_txn();
    tick();
    begin_txn(CMD_RDSR);
    xchg(8'h00);
    end_txn();
    begin_txn(CMD_READ);
    xchg(8'hF9);
    xchg(8'h00);
    xchg(8'hFF);
    end_txn();
  endtask

  task automatic test_command_set();
    write_register(CFG_WRITE_CYCLE_TICKS, 48'd2);
    write_register(CFG_UNIQUE_ID, UID_ALL_ONE);
    // A write without the enable latch is dropped whole.
    begin_txn(CMD_WRITE);
    xchg(8'h00);
    xchg(8'hAA);
    end_txn();
    begin_txn(CMD_WREN);
    end_txn();
    // Deassert before any data keeps the latch.
    begin_txn(CMD_WRITE);
    xchg(8'h1E);
    end_txn();
    // Three data bytes from 0x1E wrap inside the page.
    begin_txn(CMD_WRITE);
    xchg(8'h1E);
    xchg(8'h11);
    xchg(8'h22);
    xchg(8'h33);
    end_txn();
    // A read while busy is ignored; status shows the write in progress.
    begin_txn(CMD_READ);
    xchg(8'h1E);
    xchg(8'h00);
    end_txn();
    begin_txn(CMD_RDSR);
    xchg(8'h00);
    end_txn();
    tick();
    tick();
    // A second assert drops the enable command before its deassert.
    begin_txn(CMD_WREN);
    begin_txn(CMD_RDSR);
    xchg(8'hFF);
    end_txn();
    // Read across the ID bytes and the end of memory.
    begin_txn(CMD_READ);
    xchg(8'hFE);
    xchg(8'h00);
    xchg(8'h00);
    xchg(8'h00);
    xchg(8'h00);
    end_txn();
    begin_txn(BOGUS_CMD);
    xchg(8'h03);
    end_txn();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input logic [15:0] ticks, input logic [47:0] uid,
                                     input int beats);
    int stop_at;
    write_register(CFG_WRITE_CYCLE_TICKS, {32'd0, ticks});
    write_register(CFG_UNIQUE_ID, uid);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) random_transaction();
  endtask

  // Longest write cycle: busy must hold across the ticks that follow.
  task automatic test_long_write_cycle();
    write_register(CFG_WRITE_CYCLE_TICKS, 48'd65535);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    while (m_busy != 0) tick();
    begin_txn(CMD_WREN);
    end_txn();
    begin_txn(CMD_WRITE);
    xchg(8'hF8);
    xchg(8'h5A);
    xchg(8'hA5);
    xchg(8'hC3);
    end_txn();
    repeat (4) tick();
    begin_txn(CMD_RDSR);
    xchg(8'h00);
    end_txn();
  endtask

  // Scoreboard: every popped beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_res_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got miso %02h busy %0b",
                   $time, miso_byte, busy_res);
          error_count++;
        end else begin
          head_res = due_res_q.pop_front();
          results_checked++;
          if (miso_byte !== head_res.miso) begin
            $display("%0t: miso_byte expected %02h got %02h", $time, head_res.miso, miso_byte);
            error_count++;
          end
          if (busy_res !== head_res.busy) begin
            $display("%0t: busy_res expected %0b got %0b", $time, head_res.busy, busy_res);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) m_cells[i] = 8'hFF;
    m_ticks = TICKS_RESET;
    m_uid = '0;
    m_sel = 1'b0;
    m_phase = PH_CMD;
    m_cmd = '0;
    m_addr = '0;
    m_wel = 1'b0;
    m_busy = '0;
    page_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_command_set();
    test_random_traffic(0, 0, 16'd1, UID_ALL_ONE, 175);
    test_random_traffic(81, 0, 16'($urandom_range(6, 2)), 48'({$urandom, $urandom}), 175);
    test_random_traffic(0, 81, 16'd8, 48'd0, 175);
    test_random_traffic(27, 27, 16'($urandom_range(4, 1)), 48'({$urandom, $urandom}), 175);
    test_long_write_cycle();

    push <= 1'b0;
    while (due_res_q.size() != 0) @(posedge clk);
    repeat (PAGE_SIZE + 24) @(posedge clk);

    $display("Ran %0d request beats with %0d results checked and %0d register writes,",
             beats_sent, results_checked, cfg_writes);
    $display("through directed commands and four idle and stall mixes; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
